// ===== src/money_flow_index_assert.svh =====
// ----------------------------------------------------------------------------
// money_flow_index_assert.svh
// Assertion macros for the money flow index block. Each one samples on clk
// and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MONEY_FLOW_INDEX_ASSERT_SVH
`define MONEY_FLOW_INDEX_ASSERT_SVH

`ifndef ASSERT_OFF

// ante holds -> cons holds in the same cycle
`define MFI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds in the next cycle
`define MFI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MFI_ASSERT_SAME(lbl, ante, cons, msg)
`define MFI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/mfi_pkg.sv =====
// ----------------------------------------------------------------------------
// mfi_pkg
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mfi_pkg;

    localparam int PRICE_W        = 24;
    localparam int VOL_W          = 24;
    localparam int PROD_W         = PRICE_W + VOL_W;
    localparam int CFG_W          = 7;
    localparam int INDEX_W        = 14;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 16;
    localparam int OUT_USER_W     = 2;
    localparam int WINDOW_MAX_DEF = 64;

    localparam logic [CFG_W-1:0]   WINDOW_LEN_RESET = 7'd14;
    localparam logic [INDEX_W-1:0] SCALE            = 14'd10000;

    // controller -> datapath
    typedef struct packed {
        logic cfg_write;
        logic load_in;
        logic do_mul;
        logic do_sub;
        logic do_add;
        logic do_prep;
        logic do_num;
        logic do_div;
        logic load_out;
    } mfi_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } mfi_sts_t;

endpackage

// ===== src/mfi_ram.sv =====
// ----------------------------------------------------------------------------
// mfi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfi_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mfi_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfi_ctrl
// Sequencer for one item: product, window update, ratio setup, 14-step
// restoring divide, then hand-off into the output register.
// ----------------------------------------------------------------------------
module mfi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  mfi_pkg::mfi_sts_t sts,
    output mfi_pkg::mfi_cmd_t cmd
);
    import mfi_pkg::*;

    localparam int CNT_W = $clog2(INDEX_W);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_SUB  = 8'b0000_0100,
        ST_ADD  = 8'b0000_1000,
        ST_PREP = 8'b0001_0000,
        ST_NUM  = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              div_last;

    // config has priority over a waiting item
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign div_last      = (cnt_reg == CNT_W'(INDEX_W - 1));

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.cfg_write = cfg_valid && cfg_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.do_sub = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.do_add = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.do_prep = 1'b1;
                state_next  = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.do_num = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.do_div = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== src/mfi_dp.sv =====
// ----------------------------------------------------------------------------
// mfi_dp
// Datapath: window registers, flow ring, running sums, ratio divider and
// output register.
// ----------------------------------------------------------------------------
module mfi_dp #(
    parameter int WINDOW_MAX = mfi_pkg::WINDOW_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mfi_pkg::mfi_cmd_t               cmd,
    output mfi_pkg::mfi_sts_t               sts,
    input  logic [mfi_pkg::CFG_W-1:0]       cfg_data,
    input  logic [mfi_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            m_axis_tready,
    output logic                            m_axis_tvalid,
    output logic [mfi_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [mfi_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import mfi_pkg::*;

    localparam int PTR_W    = $clog2(WINDOW_MAX);
    localparam int WMAX_EFF = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
    localparam int SUM_W    = PROD_W + $clog2(WMAX_EFF);
    localparam int LO_W     = 32;
    localparam int HI_W     = SUM_W - LO_W;
    localparam int PPLO_W   = LO_W + INDEX_W;
    localparam int PPHI_W   = HI_W + INDEX_W;
    localparam int NUM_W    = SUM_W + INDEX_W;
    localparam int ENTRY_W  = PROD_W + 2;

    // window and control state
    logic [CFG_W-1:0]    wlen_reg, wlen_next;
    logic [PRICE_W-1:0]  last_price_reg, last_price_next;
    logic                have_last_reg, have_last_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [CFG_W-1:0]    filled_reg, filled_next;
    logic [SUM_W-1:0]    pos_reg, pos_next;
    logic [SUM_W-1:0]    neg_reg, neg_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [VOL_W-1:0]    vol_reg, vol_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                rise_reg, rise_next;
    logic                fall_reg, fall_next;
    logic [SUM_W-1:0]    total_reg, total_next;
    logic [PPLO_W-1:0]   pplo_reg, pplo_next;
    logic [PPHI_W-1:0]   pphi_reg, pphi_next;
    logic [SUM_W-1:0]    rem_reg, rem_next;
    logic [INDEX_W-1:0]  shift_reg, shift_next;
    logic                zero_reg, zero_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic                vres_reg, vres_next;
    logic                undef_reg, undef_next;

    logic                full;
    logic [ENTRY_W-1:0]  entry;
    logic [ENTRY_W-1:0]  rd_data;
    logic                ram_we;
    logic [PTR_W:0]      ptr_inc;
    logic [NUM_W-1:0]    num;
    logic [SUM_W:0]      trial;
    logic [SUM_W:0]      diff;
    logic                ge;

    assign full    = (filled_reg >= wlen_reg);
    assign entry   = (rise_reg || fall_reg) ? {fall_reg, rise_reg, prod_reg} : '0;
    assign ram_we  = cmd.do_sub && have_last_reg;
    assign ptr_inc = {1'b0, ptr_reg} + (PTR_W+1)'(1);
    assign num     = NUM_W'({pphi_reg, {LO_W{1'b0}}}) + NUM_W'(pplo_reg);
    assign trial   = {rem_reg, shift_reg[INDEX_W-1]};
    assign diff    = trial - {1'b0, total_reg};
    assign ge      = (trial >= {1'b0, total_reg});

    // ring entry: product, bit 48 marks positive, bit 49 marks negative
    mfi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ptr_reg),
        .wr_data (entry),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        wlen_next       = wlen_reg;
        last_price_next = last_price_reg;
        have_last_next  = have_last_reg;
        ptr_next        = ptr_reg;
        filled_next     = filled_reg;
        pos_next        = pos_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg;
        price_next      = price_reg;
        vol_next        = vol_reg;
        prod_next       = prod_reg;
        rise_next       = rise_reg;
        fall_next       = fall_reg;
        total_next      = total_reg;
        pplo_next       = pplo_reg;
        pphi_next       = pphi_reg;
        rem_next        = rem_reg;
        shift_next      = shift_reg;
        zero_next       = zero_reg;
        index_next      = index_reg;
        vres_next       = vres_reg;
        undef_next      = undef_reg;

        if (cmd.load_in)
        begin
            price_next = s_axis_tdata[PRICE_W-1:0];
            vol_next   = s_axis_tdata[PRICE_W+VOL_W-1:PRICE_W];
        end

        if (cmd.do_mul)
        begin
            prod_next = PROD_W'(price_reg) * PROD_W'(vol_reg);
            rise_next = (price_reg > last_price_reg);
            fall_next = (price_reg < last_price_reg);
        end

        // retire the oldest entry once the window is full
        if (cmd.do_sub && have_last_reg)
        begin
            if (full)
            begin
                if (rd_data[PROD_W])
                begin
                    pos_next = pos_reg - SUM_W'(rd_data[PROD_W-1:0]);
                end
                else if (rd_data[PROD_W+1])
                begin
                    neg_next = neg_reg - SUM_W'(rd_data[PROD_W-1:0]);
                end
            end
            else
            begin
                filled_next = filled_reg + CFG_W'(1);
            end
            if (32'(ptr_inc) >= 32'(wlen_reg))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_inc[PTR_W-1:0];
            end
        end

        if (cmd.do_add)
        begin
            if (have_last_reg)
            begin
                if (rise_reg)
                begin
                    pos_next = pos_reg + SUM_W'(prod_reg);
                end
                else if (fall_reg)
                begin
                    neg_next = neg_reg + SUM_W'(prod_reg);
                end
            end
            last_price_next = price_reg;
            have_last_next  = 1'b1;
        end

        // numerator pos*10000 split in two partial products
        if (cmd.do_prep)
        begin
            total_next = pos_reg + neg_reg;
            pplo_next  = PPLO_W'(pos_reg[LO_W-1:0]) * PPLO_W'(SCALE);
            pphi_next  = PPHI_W'(pos_reg[SUM_W-1:LO_W]) * PPHI_W'(SCALE);
        end

        // quotient < 2^14, so the upper numerator bits start below total
        if (cmd.do_num)
        begin
            rem_next   = num[NUM_W-1:INDEX_W];
            shift_next = num[INDEX_W-1:0];
            zero_next  = (total_reg == '0);
        end

        if (cmd.do_div)
        begin
            rem_next   = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            shift_next = {shift_reg[INDEX_W-2:0], ge};
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            index_next     = zero_reg ? '0 : shift_reg;
            undef_next     = zero_reg;
            vres_next      = (filled_reg == wlen_reg);
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.cfg_write)
        begin
            if (cfg_data == '0)
            begin
                wlen_next = CFG_W'(1);
            end
            else if (32'(cfg_data) > 32'(WINDOW_MAX))
            begin
                wlen_next = CFG_W'(WINDOW_MAX);
            end
            else
            begin
                wlen_next = cfg_data;
            end
            last_price_next = '0;
            have_last_next  = 1'b0;
            ptr_next        = '0;
            filled_next     = '0;
            pos_next        = '0;
            neg_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg       <= WINDOW_LEN_RESET;
            last_price_reg <= '0;
            have_last_reg  <= 1'b0;
            ptr_reg        <= '0;
            filled_reg     <= '0;
            pos_reg        <= '0;
            neg_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wlen_reg       <= wlen_next;
            last_price_reg <= last_price_next;
            have_last_reg  <= have_last_next;
            ptr_reg        <= ptr_next;
            filled_reg     <= filled_next;
            pos_reg        <= pos_next;
            neg_reg        <= neg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        vol_reg   <= vol_next;
        prod_reg  <= prod_next;
        rise_reg  <= rise_next;
        fall_reg  <= fall_next;
        total_reg <= total_next;
        pplo_reg  <= pplo_next;
        pphi_reg  <= pphi_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        zero_reg  <= zero_next;
        index_reg <= index_next;
        vres_reg  <= vres_next;
        undef_reg <= undef_next;
    end

    assign sts.out_free  = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(index_reg);
    assign m_axis_tuser  = {undef_reg, vres_reg};

endmodule

// ===== src/money_flow_index.sv =====
// ----------------------------------------------------------------------------
// money_flow_index
// Money flow index over a sliding window of price changes, in hundredths.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  price, volume
//  m_axis    out        m_axis_tvalid / m_axis_tready  index; valid_res, undefined
//  cfg       in         cfg_valid / cfg_ready          window_length
//
//  After an item is accepted, the block forms the product, updates the window
//  and sets up the ratio, runs the 14-iteration restoring divider that forms
//  10000*pos/(pos+neg), and loads the output register. A new item is taken
//  only once the block is back in idle, so it works on one item at a time.
//  The output register holds the result while m_axis_tready is low; a second
//  item then waits in the last step until the register is free.
//  Reset and window length writes clear history; the ring needs no clearing.
// ----------------------------------------------------------------------------
`include "money_flow_index_assert.svh"

module money_flow_index #(
    parameter int WINDOW_MAX = mfi_pkg::WINDOW_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mfi_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // price[23:0], volume[47:24]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mfi_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // index[13:0], zero pad
    output logic [mfi_pkg::OUT_USER_W-1:0] m_axis_tuser,   // valid_res[0], undefined[1]
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mfi_pkg::CFG_W-1:0]      cfg_data        // window_length
);
    import mfi_pkg::*;

    mfi_cmd_t cmd;
    mfi_sts_t sts;
    logic     s_acc;
    logic     cfg_acc;

    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = cfg_valid && cfg_ready;

    mfi_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    mfi_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `MFI_ASSERT_SAME(a_no_dual_accept, s_acc, !cfg_acc, "item and config taken together")
    `MFI_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_axis_tready, "item taken while busy")
    `MFI_ASSERT_SAME(a_index_range, m_axis_tvalid, m_axis_tdata[13:0] <= 14'd10000, "index out of range")
    `MFI_ASSERT_SAME(a_undef_zero, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[13:0] == 14'd0, "undefined index not zero")

endmodule
